### sv/xoshiro_byte_generator_core_assert.svh
// assertion macros shared by the generator rtl
`ifndef XOSHIRO_BYTE_GENERATOR_CORE_ASSERT_SVH
`define XOSHIRO_BYTE_GENERATOR_CORE_ASSERT_SVH

// condition in this cycle implies consequence in this cycle
`define XBG_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define XBG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/xbg_pkg.sv
// types and constants of the xoshiro byte generator
package xbg_pkg;

   // request limits and counter sizes
   localparam int MAX_REQUEST     = 64;
   localparam int CNT_WIDTH       = $clog2(MAX_REQUEST + 1);
   localparam int GEN_WORDS       = 4;
   localparam int BYTES_PER_WORD  = 8;
   localparam int BYTE_IDX_WIDTH  = $clog2(BYTES_PER_WORD);
   localparam logic [BYTE_IDX_WIDTH-1:0] LAST_BYTE_INDEX = BYTE_IDX_WIDTH'(BYTES_PER_WORD - 1);

   // seeding and mixing constants
   localparam logic [63:0] SEED_MASK = 64'h5341504F5445524E;
   localparam logic [63:0] SM_GAMMA  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] SM_MUL1   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] SM_MUL2   = 64'h94D049BB133111EB;
   localparam logic [63:0] ZERO_FIX  = 64'h6A09E667F3BCC909;
   localparam logic [63:0] MUL_BY_5  = 64'd5;
   localparam logic [63:0] MUL_BY_9  = 64'd9;

   // action codes
   localparam logic ACTION_SEED     = 1'b0;
   localparam logic ACTION_GENERATE = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [1:0] STATUS_NOT_INIT  = 2'd2;

   // capability codes
   localparam logic [1:0] CAP_UNAVAILABLE = 2'd0;
   localparam logic [1:0] CAP_DEGRADED    = 2'd1;
   localparam logic [1:0] CAP_INITIALIZED = 2'd2;

   // request word
   typedef struct packed {
      logic        action;
      logic [63:0] entropy;
      logic        entropy_valid;
      logic [7:0]  request_length;
   } req_type;

   // response word
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic [1:0]  status;
      logic [1:0]  capability;
      logic [63:0] byte_count;
      logic        last;
   } rsp_type;

endpackage

### sv/xbg_mul64.sv
// 64 by 64 multiplier, low half, from three 32 by 32 partial products
module xbg_mul64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product
);

   localparam logic [1:0] PHASE_LO    = 2'd0;
   localparam logic [1:0] PHASE_CROSS = 2'd1;
   localparam logic [1:0] PHASE_LAST  = 2'd2;

   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] a_ff, b_ff;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_a, op_b;
   logic [63:0] partial;

   // operand select: lo*lo, then lo*hi, then hi*lo
   always_comb begin
      op_a    = (phase_ff == PHASE_LAST)  ? a_ff[63:32] : a_ff[31:0];
      op_b    = (phase_ff == PHASE_CROSS) ? b_ff[63:32] : b_ff[31:0];
      partial = 64'(op_a) * 64'(op_b);
   end

   // accumulate, cross terms only touch the upper half
   always_comb begin
      if (phase_ff == PHASE_LO) begin
         acc_in = partial;
      end else begin
         acc_in = acc_ff + {partial[31:0], 32'd0};
      end
   end

   // phase control
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      done_in   = active_ff && (phase_ff == PHASE_LAST);
      if (start) begin
         active_in = 1'b1;
         phase_in  = PHASE_LO;
      end else if (active_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == PHASE_LAST) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         phase_ff  <= PHASE_LO;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         phase_ff  <= phase_in;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      if (active_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### sv/xoshiro_byte_generator_core.sv
// top level: xoshiro256** byte generator with splitmix64 seeding and its sequencer
// One request word is taken at a time; req_stall stays high until its last response word
// has been loaded into the output register. All multiplications go through one shared
// 64-bit multiplier that forms each product from three 32x32 partial products and
// registers the result. A seed takes four splitmix64 steps. A generate request of n
// bytes draws ceil(n/8) words; each word costs two products, then one byte per cycle
// while the response side takes words. The products of the next word start with the
// last byte of the word before. A rejected or zero-length request gives one response word.
`include "xoshiro_byte_generator_core_assert.svh"

module xoshiro_byte_generator_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  xbg_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output xbg_pkg::rsp_type rsp_data
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SM_ADD  = 9'b000000010,
      ST_SM_MUL1 = 9'b000000100,
      ST_SM_MUL2 = 9'b000001000,
      ST_SM_FIX  = 9'b000010000,
      ST_XO_MUL5 = 9'b000100000,
      ST_XO_MUL9 = 9'b001000000,
      ST_EMIT    = 9'b010000000,
      ST_RESP    = 9'b100000000
   } state_type;

   state_type                          state_ff, state_in;
   xbg_pkg::req_type                   req_ff, req_in;
   logic [63:0]                        gen_ff [xbg_pkg::GEN_WORDS];
   logic [63:0]                        gen_in [xbg_pkg::GEN_WORDS];
   logic [63:0]                        acc_ff, acc_in;
   logic [63:0]                        word_ff, word_in;
   logic [1:0]                         j_ff, j_in;
   logic [1:0]                         cap_ff, cap_in;
   logic [63:0]                        issued_ff, issued_in;
   logic [xbg_pkg::CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [xbg_pkg::BYTE_IDX_WIDTH-1:0] byte_idx_ff, byte_idx_in;
   logic [1:0]                         resp_status_ff, resp_status_in;
   logic                               rsp_valid_ff;
   xbg_pkg::rsp_type                   rsp_data_ff;

   logic             mul_start, mul_done;
   logic [63:0]      mul_a, mul_b, mul_product;
   logic             rsp_load, out_free, req_accept, all_zero;
   xbg_pkg::rsp_type rsp_next;
   logic [63:0]      acc_sum, sm_x1, sm_x2, sm_out, xo_rot;
   logic [63:0]      xo_t, xo_s0, xo_s1, xo_s2, xo_s3, xo_s3x;
   logic             mul_wait, seed_done, byte_load;

   // shared multiplier
   xbg_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   // splitmix64 and output mixing around the multiplier
   always_comb begin
      acc_sum  = acc_ff + xbg_pkg::SM_GAMMA;
      sm_x1    = acc_sum ^ (acc_sum >> 30);
      sm_x2    = mul_product ^ (mul_product >> 27);
      sm_out   = mul_product ^ (mul_product >> 31);
      xo_rot   = {mul_product[56:0], mul_product[63:57]};
      all_zero = ((gen_ff[0] | gen_ff[1] | gen_ff[2] | gen_ff[3]) == 64'd0);
   end

   // xoshiro256 state transition
   always_comb begin
      xo_t   = gen_ff[1] << 17;
      xo_s2  = gen_ff[2] ^ gen_ff[0];
      xo_s3x = gen_ff[3] ^ gen_ff[1];
      xo_s1  = gen_ff[1] ^ xo_s2;
      xo_s0  = gen_ff[0] ^ xo_s3x;
      xo_s3  = {xo_s3x[18:0], xo_s3x[63:19]};
   end

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      gen_in         = gen_ff;
      acc_in         = acc_ff;
      word_in        = word_ff;
      j_in           = j_ff;
      cap_in         = cap_ff;
      issued_in      = issued_ff;
      cnt_in         = cnt_ff;
      byte_idx_in    = byte_idx_ff;
      resp_status_in = resp_status_ff;
      mul_start      = 1'b0;
      mul_a          = gen_ff[1];
      mul_b          = xbg_pkg::MUL_BY_5;
      rsp_load       = 1'b0;
      rsp_next.data_byte    = 8'd0;
      rsp_next.byte_valid   = 1'b0;
      rsp_next.status       = resp_status_ff;
      rsp_next.capability   = cap_ff;
      rsp_next.byte_count   = issued_ff;
      rsp_next.last         = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_data;
               if (req_data.action == xbg_pkg::ACTION_SEED) begin
                  acc_in   = req_data.entropy ^ xbg_pkg::SEED_MASK;
                  j_in     = 2'd0;
                  state_in = ST_SM_ADD;
               end else if (req_data.request_length > 8'(xbg_pkg::MAX_REQUEST)) begin
                  resp_status_in = xbg_pkg::STATUS_TOO_LARGE;
                  state_in       = ST_RESP;
               end else if (cap_ff == xbg_pkg::CAP_UNAVAILABLE) begin
                  resp_status_in = xbg_pkg::STATUS_NOT_INIT;
                  state_in       = ST_RESP;
               end else if (req_data.request_length == 8'd0) begin
                  resp_status_in = xbg_pkg::STATUS_OK;
                  state_in       = ST_RESP;
               end else begin
                  cnt_in    = req_data.request_length[xbg_pkg::CNT_WIDTH-1:0];
                  mul_start = 1'b1;
                  state_in  = ST_XO_MUL5;
               end
            end
         end
         // splitmix64 step: add gamma, then two xor-shift-multiply rounds
         ST_SM_ADD: begin
            acc_in    = acc_sum;
            mul_start = 1'b1;
            mul_a     = sm_x1;
            mul_b     = xbg_pkg::SM_MUL1;
            state_in  = ST_SM_MUL1;
         end
         ST_SM_MUL1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = sm_x2;
               mul_b     = xbg_pkg::SM_MUL2;
               state_in  = ST_SM_MUL2;
            end
         end
         ST_SM_MUL2: begin
            if (mul_done) begin
               gen_in[j_ff] = sm_out;
               if (j_ff == 2'(xbg_pkg::GEN_WORDS - 1)) begin
                  state_in = ST_SM_FIX;
               end else begin
                  j_in     = j_ff + 2'd1;
                  state_in = ST_SM_ADD;
               end
            end
         end
         // all-zero state guard and capability update
         ST_SM_FIX: begin
            if (all_zero) begin
               gen_in[0] = xbg_pkg::ZERO_FIX;
            end
            issued_in      = 64'd0;
            cap_in         = req_ff.entropy_valid ? xbg_pkg::CAP_INITIALIZED
                                                  : xbg_pkg::CAP_DEGRADED;
            resp_status_in = xbg_pkg::STATUS_OK;
            state_in       = ST_RESP;
         end
         // output word: rotl(s1 * 5, 7) * 9, then advance the state
         ST_XO_MUL5: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = xo_rot;
               mul_b     = xbg_pkg::MUL_BY_9;
               state_in  = ST_XO_MUL9;
            end
         end
         ST_XO_MUL9: begin
            if (mul_done) begin
               word_in     = mul_product;
               gen_in[0]   = xo_s0;
               gen_in[1]   = xo_s1;
               gen_in[2]   = xo_s2 ^ xo_t;
               gen_in[3]   = xo_s3;
               byte_idx_in = '0;
               state_in    = ST_EMIT;
            end
         end
         // one byte per free output slot, least significant first
         ST_EMIT: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_next.data_byte    = word_ff[7:0];
               rsp_next.byte_valid   = 1'b1;
               rsp_next.status       = xbg_pkg::STATUS_OK;
               rsp_next.byte_count   = issued_ff + 64'd1;
               rsp_next.last         = (cnt_ff == xbg_pkg::CNT_WIDTH'(1));
               issued_in             = issued_ff + 64'd1;
               word_in               = word_ff >> 8;
               cnt_in                = cnt_ff - xbg_pkg::CNT_WIDTH'(1);
               byte_idx_in           = byte_idx_ff + xbg_pkg::BYTE_IDX_WIDTH'(1);
               if (cnt_ff == xbg_pkg::CNT_WIDTH'(1)) begin
                  state_in = ST_IDLE;
               end else if (byte_idx_ff == xbg_pkg::LAST_BYTE_INDEX) begin
                  mul_start = 1'b1;
                  state_in  = ST_XO_MUL5;
               end
            end
         end
         // single status word
         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= xbg_pkg::CAP_UNAVAILABLE;
         issued_ff <= 64'd0;
         for (int i = 0; i < xbg_pkg::GEN_WORDS; i++) begin
            gen_ff[i] <= 64'd0;
         end
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         issued_ff <= issued_in;
         gen_ff    <= gen_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      acc_ff         <= acc_in;
      word_ff        <= word_in;
      j_ff           <= j_in;
      cnt_ff         <= cnt_in;
      byte_idx_ff    <= byte_idx_in;
      resp_status_ff <= resp_status_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // terms for the checks
   assign mul_wait  = (state_ff == ST_SM_MUL1) || (state_ff == ST_SM_MUL2) ||
                      (state_ff == ST_XO_MUL5) || (state_ff == ST_XO_MUL9);
   assign seed_done = (issued_ff == 64'd0) && (cap_ff != xbg_pkg::CAP_UNAVAILABLE) &&
                      (state_ff == ST_RESP);
   assign byte_load = rsp_load && rsp_next.byte_valid;

   // checks
   `XBG_ASSERT_IMPLY(a_mul_done_awaited, mul_done, mul_wait, "product arrived while not waiting")
   `XBG_ASSERT_NEXT(a_seed_sets_state, state_ff == ST_SM_FIX, seed_done, "seed not applied")
   `XBG_ASSERT_IMPLY(a_emit_has_bytes, state_ff == ST_EMIT, cnt_ff != '0, "no bytes left")
   `XBG_ASSERT_NEXT(a_count_step, byte_load, issued_ff == $past(issued_ff) + 64'd1, "bad count")

endmodule

### sim/xoshiro_byte_generator_core_test.sv
// self-checking testbench for the xoshiro byte generator core
module xoshiro_byte_generator_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 5;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 200;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   xbg_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   xbg_pkg::rsp_type rsp_data;

   // generator image kept alongside the block
   logic [63:0] gen_words [xbg_pkg::GEN_WORDS];
   logic [1:0]  cap_code;
   logic [63:0] issued_total;

   // response words still to come, oldest first
   xbg_pkg::rsp_type awaited_words [$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_count = 0;

   xoshiro_byte_generator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // free-running clock
   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("** xoshiro_byte_generator_core: FAILED **");
      $finish;
   end

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int k);
      return (v << k) | (v >> (64 - k));
   endfunction

   // one splitmix64 step, advancing the accumulator
   function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
      logic [63:0] z;
      acc = acc + xbg_pkg::SM_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * xbg_pkg::SM_MUL1;
      z = (z ^ (z >> 27)) * xbg_pkg::SM_MUL2;
      return z ^ (z >> 31);
   endfunction

   // one xoshiro256** output, advancing the generator image
   function automatic logic [63:0] xoshiro_next();
      logic [63:0] res;
      logic [63:0] t;
      res = rotl64(gen_words[1] * xbg_pkg::MUL_BY_5, 7) * xbg_pkg::MUL_BY_9;
      t = gen_words[1] << 17;
      gen_words[2] ^= gen_words[0];
      gen_words[3] ^= gen_words[1];
      gen_words[1] ^= gen_words[2];
      gen_words[0] ^= gen_words[3];
      gen_words[2] ^= t;
      gen_words[3] = rotl64(gen_words[3], 45);
      return res;
   endfunction

   // queue the response words that one request word causes
   task automatic predict_generator(input xbg_pkg::req_type w);
      xbg_pkg::rsp_type r;
      logic [63:0]      acc;
      logic [63:0]      word;
      int               n;
      r = '0;
      r.last = 1'b1;
      if (w.action == xbg_pkg::ACTION_SEED) begin
         acc = w.entropy ^ xbg_pkg::SEED_MASK;
         for (int j = 0; j < xbg_pkg::GEN_WORDS; j++) gen_words[j] = splitmix_next(acc);
         if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 64'd0) begin
            gen_words[0] = xbg_pkg::ZERO_FIX;
         end
         issued_total = '0;
         cap_code = w.entropy_valid ? xbg_pkg::CAP_INITIALIZED : xbg_pkg::CAP_DEGRADED;
         r.status = xbg_pkg::STATUS_OK;
         r.capability = cap_code;
         r.byte_count = issued_total;
         awaited_words.push_back(r);
      end else if (int'(w.request_length) > xbg_pkg::MAX_REQUEST) begin
         r.status = xbg_pkg::STATUS_TOO_LARGE;
         r.capability = cap_code;
         r.byte_count = issued_total;
         awaited_words.push_back(r);
      end else if (cap_code == xbg_pkg::CAP_UNAVAILABLE) begin
         r.status = xbg_pkg::STATUS_NOT_INIT;
         r.capability = cap_code;
         r.byte_count = issued_total;
         awaited_words.push_back(r);
      end else if (w.request_length == 8'd0) begin
         r.status = xbg_pkg::STATUS_OK;
         r.capability = cap_code;
         r.byte_count = issued_total;
         awaited_words.push_back(r);
      end else begin
         n = int'(w.request_length);
         word = '0;
         for (int i = 0; i < n; i++) begin
            // each request starts on a fresh output word
            if (i % xbg_pkg::BYTES_PER_WORD == 0) word = xoshiro_next();
            issued_total = issued_total + 64'd1;
            r.data_byte = word[7:0];
            r.byte_valid = 1'b1;
            r.status = xbg_pkg::STATUS_OK;
            r.capability = cap_code;
            r.byte_count = issued_total;
            r.last = (i + 1 == n);
            awaited_words.push_back(r);
            word = word >> 8;
         end
      end
   endtask

   // offer one request word, hold it until taken, then maybe idle
   task automatic send_word(input xbg_pkg::req_type w);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_generator(w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop offering and wait for every queued response word
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0) @(posedge clock);
   endtask

   function automatic xbg_pkg::req_type make_word(input logic action,
                                                  input logic [63:0] entropy,
                                                  input logic ev, input logic [7:0] len);
      xbg_pkg::req_type w;
      w.action = action;
      w.entropy = entropy;
      w.entropy_valid = ev;
      w.request_length = len;
      return w;
   endfunction

   // mostly in-range generates of random length, some seeds and oversized requests
   function automatic xbg_pkg::req_type random_word();
      int          pick;
      logic [63:0] ent;
      logic        ev;
      logic [7:0]  len;
      pick = $urandom_range(99);
      ent = {$urandom(), $urandom()};
      ev = 1'($urandom_range(1));
      if (pick < 18) len = 8'($urandom_range(255));
      else if (pick < 32) len = 8'($urandom_range(64));
      else len = 8'($urandom_range(16));
      if (pick < 10) return make_word(xbg_pkg::ACTION_SEED, ent, ev, len);
      return make_word(xbg_pkg::ACTION_GENERATE, ent, ev, len);
   endfunction

   // receiver stall, with an occasional long hold requested by the sequence
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_count <= LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic report_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      error_count++;
   endtask

   // compare each taken response word with the oldest expectation
   always @(posedge clock) begin
      xbg_pkg::rsp_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_words.size() == 0) begin
            $display("%0t ns: unexpected response word %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_word = awaited_words.pop_front();
            if (rsp_data.data_byte !== exp_word.data_byte)
               report_field("data_byte", 64'(exp_word.data_byte), 64'(rsp_data.data_byte));
            if (rsp_data.byte_valid !== exp_word.byte_valid)
               report_field("byte_valid", 64'(exp_word.byte_valid), 64'(rsp_data.byte_valid));
            if (rsp_data.status !== exp_word.status)
               report_field("status", 64'(exp_word.status), 64'(rsp_data.status));
            if (rsp_data.capability !== exp_word.capability)
               report_field("capability", 64'(exp_word.capability), 64'(rsp_data.capability));
            if (rsp_data.byte_count !== exp_word.byte_count)
               report_field("byte_count", exp_word.byte_count, rsp_data.byte_count);
            if (rsp_data.last !== exp_word.last)
               report_field("last", 64'(exp_word.last), 64'(rsp_data.last));
         end
      end
   end

   // generates before any seed: limit check first, then not initialized
   task automatic test_unseeded();
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd5));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '1, 1'b1, 8'd65));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd255));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b1, 8'd0));
   endtask

   // seeds with extreme entropy, including the one that zeroes the accumulator
   task automatic test_seeding();
      send_word(make_word(xbg_pkg::ACTION_SEED, xbg_pkg::SEED_MASK, 1'b1, 8'd0));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd9));
      send_word(make_word(xbg_pkg::ACTION_SEED, '1, 1'b0, 8'd255));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '1, 1'b1, 8'd3));
      send_word(make_word(xbg_pkg::ACTION_SEED, '0, 1'b0, 8'd0));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd7));
   endtask

   // length edges: zero, one, word boundaries, the maximum and just over
   task automatic test_lengths();
      send_word(make_word(xbg_pkg::ACTION_SEED, 64'h0123456789ABCDEF, 1'b1, 8'd0));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd0));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd1));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd8));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd9));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd64));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd65));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd128));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd63));
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_long_hold();
      hold_ticket <= hold_ticket + 1;
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd64));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd12));
      send_word(make_word(xbg_pkg::ACTION_SEED, {$urandom(), $urandom()}, 1'b1, 8'd0));
      send_word(make_word(xbg_pkg::ACTION_GENERATE, '0, 1'b0, 8'd40));
      drain_responses();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < count; k++) send_word(random_word());
      drain_responses();
   endtask

   // test sequence
   initial begin
      gen_words = '{default: '0};
      cap_code = xbg_pkg::CAP_UNAVAILABLE;
      issued_total = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 14;
      recv_idle_pct = 47;
      test_unseeded();
      test_seeding();
      test_lengths();
      drain_responses();
      test_long_hold();

      test_random(75, 14, 47);
      test_random(75, 47, 14);
      test_random(70, 0, 0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_words.size() == 0) begin
         $display("** xoshiro_byte_generator_core: PASSED **");
      end else begin
         if (awaited_words.size() != 0)
            $display("%0t ns: %0d response words never arrived", $time, awaited_words.size());
         $display("** xoshiro_byte_generator_core: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/xbg_pkg.sv
sv/xbg_mul64.sv
sv/xoshiro_byte_generator_core.sv
sim/xoshiro_byte_generator_core_test.sv
